// ----- src/camera_basis_from_yaw_pitch_top_macros.svh -----
// Assertion macros for the camera basis block.
`ifndef CAMERA_BASIS_FROM_YAW_PITCH_TOP_MACROS_SVH
`define CAMERA_BASIS_FROM_YAW_PITCH_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define CBYP_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("%m: check failed");
`define CBYP_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("%m: check failed");
`else
`define CBYP_ASSERT_IMP(lbl, cond, prop)
`define CBYP_ASSERT_NXT(lbl, cond, prop)
`endif
`endif

// ----- src/cbyp_pkg.sv -----
package cbyp_pkg;

  typedef logic signed [15:0] angle_t;
  typedef logic signed [15:0] q14_t;
  typedef logic signed [31:0] q30_t;
  typedef logic signed [25:0] cz_t;

  typedef struct packed {
    q30_t x;
    q30_t y;
    q30_t z;
  } vec_t;

  typedef struct packed {
    vec_t fwd;
    logic fallback;
    logic degen;
  } side_f_t;

  typedef struct packed {
    vec_t fwd;
    vec_t rgt;
    logic fallback;
    logic degen;
  } side_r_t;

  typedef enum logic [1:0] {
    REG_UP_X = 2'd0,
    REG_UP_Y = 2'd1,
    REG_UP_Z = 2'd2
  } reg_idx_t;

  localparam int VECTOR_FRACTION_BITS_DEF = 14;
  localparam int TRIG_ITERATIONS_DEF = 16;
  localparam int ADDR_W = 4;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 31;
  localparam int ANGLE_LIMIT = 23040;
  localparam int HALF_TURN = 11520;
  localparam int QUARTER_TURN = 5760;
  localparam int REG_LIMIT = 16384;
  localparam longint DOT_LIMIT = 64'sd1072668082;
  localparam q30_t CORDIC_GAIN = 32'sd652032874;
  localparam q30_t Q30_ONE = 32'sd1073741824;

  localparam int ATAN_TABLE [32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

endpackage

// ----- src/cbyp_cordic.sv -----
module cbyp_cordic #(
  parameter int ITER = cbyp_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  cbyp_pkg::angle_t yaw,
  input  cbyp_pkg::angle_t pitch,
  output logic           out_valid,
  output cbyp_pkg::q30_t cos_yaw,
  output cbyp_pkg::q30_t sin_yaw,
  output cbyp_pkg::q30_t cos_pitch,
  output cbyp_pkg::q30_t sin_pitch
);
  import cbyp_pkg::*;

  angle_t ang [2];
  cz_t    z_init [2];
  logic   neg_init [2];

  logic   vld [ITER+1];
  q30_t   xs [ITER+1][2];
  q30_t   ys [ITER+1][2];
  cz_t    zs [ITER+1][2];
  logic   ng [ITER+1][2];

  assign ang[0] = yaw;
  assign ang[1] = pitch;

  always_comb begin
    logic signed [16:0] a;
    for (int l = 0; l < 2; l++) begin
      a = 17'(ang[l]);
      if (a > ANGLE_LIMIT) a = 17'(ANGLE_LIMIT);
      if (a < -ANGLE_LIMIT) a = 17'(-ANGLE_LIMIT);
      if (a > HALF_TURN) a = 17'(a - 2 * HALF_TURN);
      if (a < -HALF_TURN) a = 17'(a + 2 * HALF_TURN);
      neg_init[l] = 1'b0;
      if (a > QUARTER_TURN) begin
        a = 17'(a - HALF_TURN);
        neg_init[l] = 1'b1;
      end else if (a < -QUARTER_TURN) begin
        a = 17'(a + HALF_TURN);
        neg_init[l] = 1'b1;
      end
      z_init[l] = 26'(a * 1024);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= ITER; s++) vld[s] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int s = 0; s < ITER; s++) vld[s+1] <= vld[s];
      out_valid <= vld[ITER];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        xs[0][l] <= CORDIC_GAIN;
        ys[0][l] <= '0;
        zs[0][l] <= z_init[l];
        ng[0][l] <= neg_init[l];
      end
    end
  end

  for (genvar g = 0; g < ITER; g++) begin : g_iter
    localparam cz_t ATAN_G = cz_t'(ATAN_TABLE[g]);
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          if (zs[g][l] >= 0) begin
            xs[g+1][l] <= xs[g][l] - (ys[g][l] >>> g);
            ys[g+1][l] <= ys[g][l] + (xs[g][l] >>> g);
            zs[g+1][l] <= zs[g][l] - ATAN_G;
          end else begin
            xs[g+1][l] <= xs[g][l] + (ys[g][l] >>> g);
            ys[g+1][l] <= ys[g][l] - (xs[g][l] >>> g);
            zs[g+1][l] <= zs[g][l] + ATAN_G;
          end
          ng[g+1][l] <= ng[g][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_yaw   <= ng[ITER][0] ? -xs[ITER][0] : xs[ITER][0];
      sin_yaw   <= ng[ITER][0] ? -ys[ITER][0] : ys[ITER][0];
      cos_pitch <= ng[ITER][1] ? -xs[ITER][1] : xs[ITER][1];
      sin_pitch <= ng[ITER][1] ? -ys[ITER][1] : ys[ITER][1];
    end
  end

endmodule

// ----- src/cbyp_norm.sv -----
module cbyp_norm #(
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  cbyp_pkg::vec_t      vec_in,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output cbyp_pkg::vec_t      vec_out,
  output logic                zero_len,
  output logic [SIDE_W-1:0]   side_out
);
  import cbyp_pkg::*;

  localparam int NS = SQRT_STEPS;
  localparam int ND = DIV_STEPS;

  q30_t        vin [3];
  logic [31:0] mag_in [3];

  logic              a_vld;
  logic [31:0]       a_mag [3];
  logic              a_neg [3];
  logic [63:0]       a_sq [3];
  logic [SIDE_W-1:0] a_side;

  logic              sq_vld [NS+1];
  logic [63:0]       sq_n [NS+1];
  logic [63:0]       sq_res [NS+1];
  logic [31:0]       sq_mag [NS+1][3];
  logic              sq_neg [NS+1][3];
  logic [SIDE_W-1:0] sq_side [NS+1];

  logic              dv_vld [ND+1];
  logic [31:0]       dv_len [ND+1];
  logic [63:0]       dv_rem [ND+1][3];
  logic [ND-1:0]     dv_q [ND+1][3];
  logic              dv_neg [ND+1][3];
  logic              dv_zero [ND+1];
  logic [SIDE_W-1:0] dv_side [ND+1];

  logic [31:0]       len_fin;
  q30_t              res_k [3];

  assign vin[0] = vec_in.x;
  assign vin[1] = vec_in.y;
  assign vin[2] = vec_in.z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_in[k] = vin[k][31] ? 32'(-vin[k]) : 32'(vin[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      for (int s = 0; s <= NS; s++) sq_vld[s] <= 1'b0;
      for (int s = 0; s <= ND; s++) dv_vld[s] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
      sq_vld[0] <= a_vld;
      for (int s = 0; s < NS; s++) sq_vld[s+1] <= sq_vld[s];
      dv_vld[0] <= sq_vld[NS];
      for (int s = 0; s < ND; s++) dv_vld[s+1] <= dv_vld[s];
      out_valid <= dv_vld[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_mag[k] <= mag_in[k];
        a_neg[k] <= vin[k][31];
        a_sq[k]  <= 64'(mag_in[k]) * 64'(mag_in[k]);
      end
      a_side <= side_in;
      sq_n[0]   <= a_sq[0] + a_sq[1] + a_sq[2];
      sq_res[0] <= '0;
      for (int k = 0; k < 3; k++) begin
        sq_mag[0][k] <= a_mag[k];
        sq_neg[0][k] <= a_neg[k];
      end
      sq_side[0] <= a_side;
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
    logic [63:0] trial;
    assign trial = sq_res[g] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_n[g] >= trial) begin
          sq_n[g+1]   <= sq_n[g] - trial;
          sq_res[g+1] <= (sq_res[g] >> 1) + BIT;
        end else begin
          sq_n[g+1]   <= sq_n[g];
          sq_res[g+1] <= sq_res[g] >> 1;
        end
        for (int k = 0; k < 3; k++) begin
          sq_mag[g+1][k] <= sq_mag[g][k];
          sq_neg[g+1][k] <= sq_neg[g][k];
        end
        sq_side[g+1] <= sq_side[g];
      end
    end
  end

  assign len_fin = sq_res[NS][31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_len[0]  <= len_fin;
      dv_zero[0] <= (len_fin == '0);
      for (int k = 0; k < 3; k++) begin
        dv_rem[0][k] <= {2'b00, sq_mag[NS][k], 30'd0} + 64'(len_fin >> 1);
        dv_q[0][k]   <= '0;
        dv_neg[0][k] <= sq_neg[NS][k];
      end
      dv_side[0] <= sq_side[NS];
    end
  end

  for (genvar g = 0; g < ND; g++) begin : g_div
    logic [63:0] dvsr;
    assign dvsr = 64'(dv_len[g]) << (ND - 1 - g);
    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          if (dv_rem[g][k] >= dvsr) begin
            dv_rem[g+1][k] <= dv_rem[g][k] - dvsr;
            dv_q[g+1][k]   <= {dv_q[g][k][ND-2:0], 1'b1};
          end else begin
            dv_rem[g+1][k] <= dv_rem[g][k];
            dv_q[g+1][k]   <= {dv_q[g][k][ND-2:0], 1'b0};
          end
          dv_neg[g+1][k] <= dv_neg[g][k];
        end
        dv_len[g+1]  <= dv_len[g];
        dv_zero[g+1] <= dv_zero[g];
        dv_side[g+1] <= dv_side[g];
      end
    end
  end

  always_comb begin
    q30_t qq;
    for (int k = 0; k < 3; k++) begin
      qq = q30_t'({1'b0, dv_q[ND][k]});
      if (dv_zero[ND]) res_k[k] = '0;
      else res_k[k] = dv_neg[ND][k] ? -qq : qq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_out.x <= res_k[0];
      vec_out.y <= res_k[1];
      vec_out.z <= res_k[2];
      zero_len  <= dv_zero[ND];
      side_out  <= dv_side[ND];
    end
  end

endmodule

// ----- src/cbyp_cross.sv -----
module cbyp_cross #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  cbyp_pkg::vec_t    a,
  input  cbyp_pkg::vec_t    b,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output cbyp_pkg::vec_t    prod,
  output logic [SIDE_W-1:0] side_out
);
  import cbyp_pkg::*;

  localparam logic signed [64:0] HALF = 65'sd536870912;

  logic                vld;
  logic signed [63:0]  p [6];
  logic [SIDE_W-1:0]   side_p;
  logic signed [64:0]  d [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld <= in_valid;
      out_valid <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= 64'(a.y) * 64'(b.z);
      p[1] <= 64'(a.z) * 64'(b.y);
      p[2] <= 64'(a.z) * 64'(b.x);
      p[3] <= 64'(a.x) * 64'(b.z);
      p[4] <= 64'(a.x) * 64'(b.y);
      p[5] <= 64'(a.y) * 64'(b.x);
      side_p <= side_in;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d[k] = ((65'(p[2*k]) - 65'(p[2*k+1])) + HALF) >>> 30;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod.x   <= q30_t'(d[0][31:0]);
      prod.y   <= q30_t'(d[1][31:0]);
      prod.z   <= q30_t'(d[2][31:0]);
      side_out <= side_p;
    end
  end

endmodule

// ----- src/camera_basis_from_yaw_pitch_top.sv -----
// Camera basis from yaw and pitch.
//
// Input stream: one beat carries yaw_angle and pitch_angle in 1/64 degree.
// Output stream: one beat per input beat, in order, with the forward, right
// and up vectors in signed Q1.14 (VECTOR_FRACTION_BITS fraction bits) and
// two flags: fallback_used (reference axis switched to +z) and degenerate
// (the forward vector or a cross product had zero length).
// APB port: world_up_x/y/z at byte addresses 0, 4, 8; written values are
// clamped to [-16384, 16384]. Write only while no beat is in flight.
//
// Most of the pipeline is the CORDIC stages and three normalizers, each a
// 32-step square root followed by a 31-step restoring divider. Throughput is
// one beat per cycle while s_axis_tready is high.
// Reset clears all valid bits and loads world up = (0, 1, 0).
// When the receiver stalls, the output register holds its beat and a skid
// register catches the next one; only then does s_axis_tready drop and the
// whole pipeline freezes until the skid register drains.
module camera_basis_from_yaw_pitch_top #(
  parameter int VECTOR_FRACTION_BITS = cbyp_pkg::VECTOR_FRACTION_BITS_DEF,
  parameter int TRIG_ITERATIONS = cbyp_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // yaw_angle [15:0], pitch_angle [31:16]
  input  logic [31:0]                 s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // forward_x, forward_y, forward_z, right_x, right_y, right_z, up_x, up_y,
  // up_z, 16 bits each from bit 0 up
  output logic [143:0]                m_axis_tdata,
  // fallback_used [0], degenerate [1]
  output logic [1:0]                  m_axis_tuser,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbyp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import cbyp_pkg::*;

  `include "camera_basis_from_yaw_pitch_top_macros.svh"

  localparam int EMIT_SH = 30 - VECTOR_FRACTION_BITS;
  localparam longint EMIT_HALF = (EMIT_SH == 0) ? 0 : (64'sd1 <<< (EMIT_SH - 1));
  localparam logic signed [63:0] RND30 = 64'sd536870912;
  localparam logic signed [49:0] RND14 = 50'sd8192;

  q14_t up_x, up_y, up_z;
  q14_t wr_val;
  logic signed [15:0] wr_raw;

  logic en;
  logic skid_valid;
  logic [143:0] skid_tdata;
  logic [1:0]   skid_tuser;

  logic c_vld;
  q30_t cy, sy, cp, sp;

  logic m_vld;
  logic signed [63:0] m_cc, m_sc;
  q30_t m_sp;

  logic r_vld;
  vec_t r_raw;
  logic signed [63:0] r_t0, r_t2;

  logic n1_vld, n1_zero, n1_side;
  vec_t n1_fwd;

  logic d_vld, d_deg;
  logic signed [47:0] d_p [3];
  vec_t d_fwd;

  logic signed [49:0] dot_sum, dot_val, dot_mag;
  logic e_vld;
  vec_t e_ref;
  side_f_t e_side;

  logic c1_vld;
  vec_t c1_prod;
  side_f_t c1_side;

  logic n2_vld, n2_zero;
  vec_t n2_rgt;
  side_f_t n2_side;
  side_r_t n2_pass;

  logic c2_vld;
  vec_t c2_prod;
  side_r_t c2_side;

  logic n3_vld, n3_zero;
  vec_t n3_up;
  side_r_t n3_side;

  logic o_vld;
  logic [143:0] o_tdata;
  logic [1:0]   o_tuser;

  function automatic q14_t emit_q(q30_t v);
    logic signed [33:0] t;
    t = (34'(v) + 34'(EMIT_HALF)) >>> EMIT_SH;
    if (t > 34'sd32767) return 16'sh7fff;
    if (t < -34'sd32768) return 16'sh8000;
    return q14_t'(t[15:0]);
  endfunction

  // configuration
  assign pready = 1'b1;
  assign wr_raw = pwdata[15:0];

  always_comb begin
    if (wr_raw > REG_LIMIT) wr_val = q14_t'(REG_LIMIT);
    else if (wr_raw < -REG_LIMIT) wr_val = q14_t'(-REG_LIMIT);
    else wr_val = wr_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      up_x <= '0;
      up_y <= q14_t'(REG_LIMIT);
      up_z <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_UP_X: up_x <= wr_val;
        REG_UP_Y: up_y <= wr_val;
        REG_UP_Z: up_z <= wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_UP_X: prdata = 32'(up_x);
      REG_UP_Y: prdata = 32'(up_y);
      REG_UP_Z: prdata = 32'(up_z);
      default:  prdata = '0;
    endcase
  end

  // pipeline
  assign en = ~skid_valid;
  assign s_axis_tready = en;

  cbyp_cordic #(.ITER(TRIG_ITERATIONS)) u_cordic (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_axis_tvalid),
    .yaw(angle_t'(s_axis_tdata[15:0])),
    .pitch(angle_t'(s_axis_tdata[31:16])),
    .out_valid(c_vld),
    .cos_yaw(cy), .sin_yaw(sy), .cos_pitch(cp), .sin_pitch(sp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
      r_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
      o_vld <= 1'b0;
    end else if (en) begin
      m_vld <= c_vld;
      r_vld <= m_vld;
      d_vld <= n1_vld;
      e_vld <= d_vld;
      o_vld <= n3_vld;
    end
  end

  assign r_t0 = (m_cc + RND30) >>> 30;
  assign r_t2 = (m_sc + RND30) >>> 30;

  always_ff @(posedge clk) begin
    if (en) begin
      m_cc <= 64'(cy) * 64'(cp);
      m_sc <= 64'(sy) * 64'(cp);
      m_sp <= sp;
      r_raw.x <= q30_t'(r_t0[31:0]);
      r_raw.y <= m_sp;
      r_raw.z <= q30_t'(r_t2[31:0]);
    end
  end

  cbyp_norm #(.SIDE_W(1)) u_norm_fwd (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(r_vld), .vec_in(r_raw), .side_in(1'b0),
    .out_valid(n1_vld), .vec_out(n1_fwd), .zero_len(n1_zero), .side_out(n1_side)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      d_p[0] <= 48'(n1_fwd.x) * 48'(up_x);
      d_p[1] <= 48'(n1_fwd.y) * 48'(up_y);
      d_p[2] <= 48'(n1_fwd.z) * 48'(up_z);
      d_fwd  <= n1_fwd;
      d_deg  <= n1_zero | n1_side;
    end
  end

  assign dot_sum = 50'(d_p[0]) + 50'(d_p[1]) + 50'(d_p[2]);
  assign dot_val = (dot_sum + RND14) >>> 14;
  assign dot_mag = dot_val[49] ? -dot_val : dot_val;

  always_ff @(posedge clk) begin
    if (en) begin
      e_side.fwd   <= d_fwd;
      e_side.degen <= d_deg;
      if (dot_mag > DOT_LIMIT) begin
        e_side.fallback <= 1'b1;
        e_ref.x <= '0;
        e_ref.y <= '0;
        e_ref.z <= Q30_ONE;
      end else begin
        e_side.fallback <= 1'b0;
        e_ref.x <= 32'(up_x) <<< 16;
        e_ref.y <= 32'(up_y) <<< 16;
        e_ref.z <= 32'(up_z) <<< 16;
      end
    end
  end

  cbyp_cross #(.SIDE_W($bits(side_f_t))) u_cross_rgt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(e_vld), .a(e_side.fwd), .b(e_ref), .side_in(e_side),
    .out_valid(c1_vld), .prod(c1_prod), .side_out(c1_side)
  );

  cbyp_norm #(.SIDE_W($bits(side_f_t))) u_norm_rgt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(c1_vld), .vec_in(c1_prod), .side_in(c1_side),
    .out_valid(n2_vld), .vec_out(n2_rgt), .zero_len(n2_zero), .side_out(n2_side)
  );

  always_comb begin
    n2_pass.fwd      = n2_side.fwd;
    n2_pass.rgt      = n2_rgt;
    n2_pass.fallback = n2_side.fallback;
    n2_pass.degen    = n2_side.degen | n2_zero;
  end

  cbyp_cross #(.SIDE_W($bits(side_r_t))) u_cross_up (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(n2_vld), .a(n2_rgt), .b(n2_side.fwd), .side_in(n2_pass),
    .out_valid(c2_vld), .prod(c2_prod), .side_out(c2_side)
  );

  cbyp_norm #(.SIDE_W($bits(side_r_t))) u_norm_up (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(c2_vld), .vec_in(c2_prod), .side_in(c2_side),
    .out_valid(n3_vld), .vec_out(n3_up), .zero_len(n3_zero), .side_out(n3_side)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      o_tdata <= {emit_q(n3_up.z), emit_q(n3_up.y), emit_q(n3_up.x),
                  emit_q(n3_side.rgt.z), emit_q(n3_side.rgt.y), emit_q(n3_side.rgt.x),
                  emit_q(n3_side.fwd.z), emit_q(n3_side.fwd.y), emit_q(n3_side.fwd.x)};
      o_tuser <= {n3_side.degen | n3_zero, n3_side.fallback};
    end
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_axis_tready) skid_valid <= 1'b0;
    end else if (o_vld) begin
      if (!m_axis_tvalid || m_axis_tready) m_axis_tvalid <= 1'b1;
      else skid_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_axis_tready) begin
        m_axis_tdata <= skid_tdata;
        m_axis_tuser <= skid_tuser;
      end
    end else if (o_vld) begin
      if (!m_axis_tvalid || m_axis_tready) begin
        m_axis_tdata <= o_tdata;
        m_axis_tuser <= o_tuser;
      end else begin
        skid_tdata <= o_tdata;
        skid_tuser <= o_tuser;
      end
    end
  end

  `CBYP_ASSERT_IMP(a_skid_behind_out, skid_valid, m_axis_tvalid)
  `CBYP_ASSERT_NXT(a_skid_holds, skid_valid && !m_axis_tready, skid_valid)
  `CBYP_ASSERT_NXT(a_skid_catch, o_vld && en && m_axis_tvalid && !m_axis_tready, skid_valid)
  `CBYP_ASSERT_IMP(a_degen_up_zero, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata[143:96] == '0)
  `CBYP_ASSERT_IMP(a_fwd_nonzero, m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata[47:0] != '0)

endmodule

// ----- tb/camera_basis_from_yaw_pitch_checker.sv -----
module camera_basis_from_yaw_pitch_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [143:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [cbyp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]  pwdata,
  output int           pending,
  output int           errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import cbyp_pkg::*;

  typedef longint vec3_t [3];

  typedef struct {
    logic [15:0] comp [9];
    logic        fallback;
    logic        degen;
  } basis_t;

  basis_t basis_q [$];
  longint up_x, up_y, up_z;

  localparam string COMP_NAME [9] = '{"forward_x", "forward_y", "forward_z",
    "right_x", "right_y", "right_z", "up_x", "up_y", "up_z"};

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint rshift_round(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic void sincos(logic [15:0] raw, output longint c, output longint s);
    longint a, x, y, z, dx, dy;
    bit neg;
    a = clamp(longint'($signed(raw)), -ANGLE_LIMIT, ANGLE_LIMIT);
    neg = 0;
    if (a > HALF_TURN) a -= 2 * HALF_TURN;
    if (a < -HALF_TURN) a += 2 * HALF_TURN;
    if (a > QUARTER_TURN) begin
      a -= HALF_TURN;
      neg = 1;
    end else if (a < -QUARTER_TURN) begin
      a += HALF_TURN;
      neg = 1;
    end
    x = CORDIC_GAIN;
    y = 0;
    z = a * 1024;
    for (int i = 0; i < TRIG_ITERATIONS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TABLE[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TABLE[i];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic bit unit_vec(vec3_t v, output vec3_t o);
    longint unsigned m [3];
    longint unsigned sum, len, q;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] = v[k] < 0 ? -v[k] : v[k];
      sum += m[k] * m[k];
    end
    len = int_sqrt(sum);
    if (len == 0) begin
      o = '{0, 0, 0};
      return 1;
    end
    for (int k = 0; k < 3; k++) begin
      q = ((m[k] << 30) + len / 2) / len;
      o[k] = v[k] < 0 ? -longint'(q) : longint'(q);
    end
    return 0;
  endfunction

  function automatic vec3_t cross3(vec3_t a, vec3_t b);
    vec3_t o;
    o[0] = rshift_round(a[1] * b[2] - a[2] * b[1], 30);
    o[1] = rshift_round(a[2] * b[0] - a[0] * b[2], 30);
    o[2] = rshift_round(a[0] * b[1] - a[1] * b[0], 30);
    return o;
  endfunction

  function automatic logic [15:0] to_q14(longint q30);
    return 16'(clamp(rshift_round(q30, 30 - VECTOR_FRACTION_BITS_DEF), -32768, 32767));
  endfunction

  function automatic basis_t camera_basis(logic [15:0] yaw, logic [15:0] pitch);
    basis_t b;
    longint cy, sy, cp, sp, dot;
    vec3_t raw, fwd, axis, rgt, upv;
    sincos(yaw, cy, sy);
    sincos(pitch, cp, sp);
    raw[0] = rshift_round(cy * cp, 30);
    raw[1] = sp;
    raw[2] = rshift_round(sy * cp, 30);
    b.degen = unit_vec(raw, fwd);
    axis = '{up_x * 65536, up_y * 65536, up_z * 65536};
    dot = rshift_round(fwd[0] * axis[0] + fwd[1] * axis[1] + fwd[2] * axis[2], 30);
    if (dot < 0) dot = -dot;
    b.fallback = dot > DOT_LIMIT;
    if (b.fallback) axis = '{0, 0, longint'(Q30_ONE)};
    if (unit_vec(cross3(fwd, axis), rgt)) b.degen = 1;
    if (unit_vec(cross3(rgt, fwd), upv)) b.degen = 1;
    for (int k = 0; k < 3; k++) begin
      b.comp[k] = to_q14(fwd[k]);
      b.comp[3 + k] = to_q14(rgt[k]);
      b.comp[6 + k] = to_q14(upv[k]);
    end
    return b;
  endfunction

  assign pending = basis_q.size();

  always @(posedge clk) begin
    longint v;
    basis_t want;
    if (rst) begin
      up_x = 0;
      up_y = REG_LIMIT;
      up_z = 0;
      basis_q.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        v = clamp(longint'($signed(pwdata[15:0])), -REG_LIMIT, REG_LIMIT);
        case (paddr >> 2)
          REG_UP_X: up_x = v;
          REG_UP_Y: up_y = v;
          REG_UP_Z: up_z = v;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        basis_q.push_back(camera_basis(s_axis_tdata[15:0], s_axis_tdata[31:16]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (basis_q.size() == 0) begin
          $error("output beat with nothing expected");
          errors++;
        end else begin
          want = basis_q.pop_front();
          for (int k = 0; k < 9; k++)
            if (m_axis_tdata[16*k +: 16] !== want.comp[k]) begin
              $error("%s expected %0d actual %0d", COMP_NAME[k],
                     $signed(want.comp[k]), $signed(m_axis_tdata[16*k +: 16]));
              errors++;
            end
          if (m_axis_tuser[0] !== want.fallback) begin
            $error("fallback_used expected %0d actual %0d", want.fallback, m_axis_tuser[0]);
            errors++;
          end
          if (m_axis_tuser[1] !== want.degen) begin
            $error("degenerate expected %0d actual %0d", want.degen, m_axis_tuser[1]);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ----- tb/tb_camera_basis_from_yaw_pitch_top.sv -----
module tb_camera_basis_from_yaw_pitch_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cbyp_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  int pending;
  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;

  camera_basis_from_yaw_pitch_top dut (.*);

  camera_basis_from_yaw_pitch_checker checker_i (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .pending, .errors
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #50ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_req = 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_world_up(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while (pending != 0) @(posedge clk);
    reg_write(ADDR_W'(4 * REG_UP_X), {16'h0, x});
    reg_write(ADDR_W'(4 * REG_UP_Y), {16'h0, y});
    reg_write(ADDR_W'(4 * REG_UP_Z), {16'h0, z});
  endtask

  task automatic send_angles(logic [15:0] yaw, logic [15:0] pitch);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {pitch, yaw};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic [15:0] rand_angle();
    logic [15:0] marks [12] = '{16'sd0, 16'sd5760, -16'sd5760, 16'sd11520, -16'sd11520,
      16'sd23040, -16'sd23040, 16'sd32767, -16'sd32768, 16'sd5759, -16'sd5759, 16'sd23041};
    case ($urandom_range(9))
      7, 8: return 16'($urandom);
      9: return marks[$urandom_range(11)];
      default: return 16'(int'($urandom_range(46080)) - 23040);
    endcase
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) send_angles(rand_angle(), rand_angle());
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    logic [15:0] dir_yaw [22] = '{16'sd0, 16'sd0, 16'sd23040, -16'sd23040, 16'sd32767,
      -16'sd32768, 16'sd5760, -16'sd5760, 16'sd11520, -16'sd11520, 16'sd0, 16'sd2880,
      16'sd0, 16'sd17280, -16'sd1, 16'sd1, 16'sd23040, -16'sd32768, 16'sd4000, 16'sd0,
      16'hFFFF, 16'h5555};
    logic [15:0] dir_pitch [22] = '{16'sd0, 16'sd5760, -16'sd5760, 16'sd0, 16'sd0,
      16'sd0, 16'sd23040, -16'sd23040, 16'sd11520, 16'sd32767, -16'sd32768, 16'sd5740,
      -16'sd5759, 16'sd17280, 16'sd1, -16'sd1, 16'sd5760, 16'sd5760, 16'sd2000, 16'sd11520,
      16'hAAAA, 16'hFFFF};
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_req = 0;
    send_idle_pct = 14;
    recv_idle_pct = 60;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 22; i++) send_angles(dir_yaw[i], dir_pitch[i]);
    random_run(20);

    set_world_up(16'sd16384, 16'sd0, 16'sd0);
    for (int i = 0; i < 6; i++) send_angles(dir_yaw[i], dir_pitch[i]);
    hold_req = 1;
    random_run(250);

    set_world_up(16'sd0, 16'sd0, -16'sd16384);
    random_run(20);

    send_idle_pct = 60;
    recv_idle_pct = 14;
    set_world_up(16'sd0, 16'sd0, 16'sd0);
    for (int i = 0; i < 6; i++) send_angles(dir_yaw[i], dir_pitch[i]);
    random_run(20);

    set_world_up(16'h7FFF, 16'h8000, 16'h1234);
    reg_write(ADDR_W'(4 * 3), 32'h0000_4000);
    random_run(20);

    set_world_up(-16'sd16384, -16'sd16384, 16'sd16384);
    random_run(20);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_world_up(16'(int'($urandom_range(32768)) - 16384),
                 16'(int'($urandom_range(32768)) - 16384),
                 16'(int'($urandom_range(32768)) - 16384));
    random_run(30);

    set_world_up(16'sd0, 16'sd16384, 16'sd0);
    random_run(20);

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// ----- camera_basis_from_yaw_pitch_top.f -----
+incdir+src
src/cbyp_pkg.sv
src/cbyp_cordic.sv
src/cbyp_norm.sv
src/cbyp_cross.sv
src/camera_basis_from_yaw_pitch_top.sv
tb/camera_basis_from_yaw_pitch_checker.sv
tb/tb_camera_basis_from_yaw_pitch_top.sv
